>>> hdl/gmd_pkg.sv
// Shared types and constants of the gradient magnitude and direction core.
package gmd_pkg;

	// Configuration port
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 13;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_MAG_SCALE    = 2'd2,
		REG_UNUSED       = 2'd3
	} cfg_reg_t;

	// Register reset values
	localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic [7:0]  MAG_SCALE_RST    = 8'd80;

	// Direction codes
	localparam logic [1:0] DIR_0   = 2'd0;
	localparam logic [1:0] DIR_45  = 2'd1;
	localparam logic [1:0] DIR_90  = 2'd2;
	localparam logic [1:0] DIR_135 = 2'd3;

	// Square root: radicands below 2^24 give a 12-bit root
	localparam int unsigned SQRT_IN_W   = 24;
	localparam int unsigned SQRT_ROOT_W = 12;
	localparam int unsigned SQRT_REM_W  = 16;

endpackage

>>> hdl/gmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gmd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/gradient_magnitude_direction_core.sv
// Top level: line stores, 3x3 window, gradient magnitude and direction.
//
//  channel  | signals                               | handshake
//  ---------+---------------------------------------+-------------------------
//  pixel in | pixel[7:0]                            | in_valid / in_ready
//  result   | magnitude[7:0] direction last_of_frame| out_valid / out_ready
//  config   | cfg_index cfg_wdata[12:0]             | cfg_we, no wait
//
// An interior pixel passes through accept, row store read, two multiply
// stages, 12 iterations of the bit-serial square root and output load.
// A border pixel passes only through accept and row store read/write-back.
// The result register lets the next pixel enter while a result waits; a
// stalled output holds the core only when a second result is ready.
// Reset clears counters, window and control; row stores are not cleared.
module gradient_magnitude_direction_core #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          pixel,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          magnitude,
	output logic [1:0]                          direction,
	output logic                                last_of_frame,
	input  logic                                cfg_we,
	input  logic [gmd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [gmd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_HEIGHT);
	localparam int unsigned WW = (CW + 1 > 11) ? CW + 1 : 11;
	localparam int unsigned HW = (RW + 1 > 13) ? RW + 1 : 13;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_MUL1, S_MUL2, S_SQRT, S_OUT
	} state_t;

	state_t state_q;

	logic [10:0] frame_width_q;
	logic [12:0] frame_height_q;
	logic [7:0]  mag_scale_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= gmd_pkg::FRAME_WIDTH_RST;
			frame_height_q <= gmd_pkg::FRAME_HEIGHT_RST;
			mag_scale_q    <= gmd_pkg::MAG_SCALE_RST;
		end else if (cfg_we) begin
			unique case (gmd_pkg::cfg_reg_t'(cfg_index))
				gmd_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata[10:0];
				gmd_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata[12:0];
				gmd_pkg::REG_MAG_SCALE:    mag_scale_q    <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Effective geometry, clamped into range
	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;
	always_comb begin
		eff_w = WW'(frame_width_q);
		if (eff_w < WW'(3)) eff_w = WW'(3);
		else if (eff_w > WW'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
		eff_h = HW'(frame_height_q);
		if (eff_h < HW'(3)) eff_h = HW'(3);
		else if (eff_h > HW'(MAX_HEIGHT)) eff_h = HW'(MAX_HEIGHT);
	end

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// Position of the incoming pixel and of the next one
	logic [WW-1:0] col_eff, col_nxt;
	logic [HW-1:0] row_eff, row_nxt;
	logic          emit_c, last_c;
	always_comb begin
		col_eff = WW'(col_q);
		row_eff = HW'(row_q);
		if (col_eff >= eff_w) begin
			col_eff = '0;
			row_eff = row_eff + HW'(1);
		end
		if (row_eff >= eff_h) row_eff = '0;
		emit_c  = (row_eff >= HW'(2)) && (col_eff >= WW'(2));
		last_c  = (col_eff + WW'(1) >= eff_w) && (row_eff + HW'(1) >= eff_h);
		col_nxt = col_eff + WW'(1);
		row_nxt = row_eff;
		if (col_nxt >= eff_w) begin
			col_nxt = '0;
			row_nxt = row_eff + HW'(1);
			if (row_nxt >= eff_h) row_nxt = '0;
		end
	end

	logic in_acc;
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	// Row stores: read at acceptance, write back in the following cycle (S_RD)
	logic [CW-1:0] addr_s1;
	logic [7:0]    pixel_s1;
	logic [7:0]    older_rd, middle_rd;
	logic          wb_en;

	assign wb_en = (state_q == S_RD);

	gmd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_older_ram (
		.clk   (clk),
		.we    (wb_en),
		.waddr (addr_s1),
		.wdata (middle_rd),
		.raddr (col_eff[CW-1:0]),
		.rdata (older_rd)
	);

	gmd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_middle_ram (
		.clk   (clk),
		.we    (wb_en),
		.waddr (addr_s1),
		.wdata (pixel_s1),
		.raddr (col_eff[CW-1:0]),
		.rdata (middle_rd)
	);

	// Window taps that the central differences use
	logic [7:0] win_top_q, win_mid_a_q, win_mid_b_q, win_bot_q;

	logic signed [8:0] dx_s2, dy_s2;
	logic              emit_s1, last_s1, last_s2;

	// Direction bands from absolute differences
	logic [7:0]  abs_dx, abs_dy;
	logic [8:0]  sum_ab;
	logic [17:0] sq_sum_ab, sq_diff_ab, two_b_sq;
	logic [1:0]  dir_c;
	logic        same_sign;
	always_comb begin
		abs_dx     = dx_s2[8] ? 8'(-dx_s2) : dx_s2[7:0];
		abs_dy     = dy_s2[8] ? 8'(-dy_s2) : dy_s2[7:0];
		sum_ab     = 9'(abs_dx) + 9'(abs_dy);
		sq_sum_ab  = 18'(sum_ab) * 18'(sum_ab);
		sq_diff_ab = 18'(abs_dy - abs_dx) * 18'(abs_dy - abs_dx);
		two_b_sq   = 18'(18'(abs_dx) * 18'(abs_dx)) << 1;
		same_sign  = (dx_s2 > 9'sd0) == (dy_s2 >= 9'sd0);
		if (dx_s2 == 9'sd0) begin
			dir_c = (dy_s2 != 9'sd0) ? gmd_pkg::DIR_90 : gmd_pkg::DIR_0;
		end else if (sq_sum_ab < two_b_sq) begin
			dir_c = gmd_pkg::DIR_0;
		end else if (abs_dy <= abs_dx || sq_diff_ab < two_b_sq) begin
			dir_c = (same_sign || abs_dy == 8'd0) ? gmd_pkg::DIR_45 : gmd_pkg::DIR_135;
		end else begin
			dir_c = gmd_pkg::DIR_90;
		end
	end

	logic [16:0] grad_sq_s3;
	logic [15:0] scale_sq_s3;
	logic [1:0]  dir_s3;
	logic        last_s3;
	logic [32:0] product;

	assign product = 33'(scale_sq_s3) * 33'(grad_sq_s3);

	// Bit-serial square root
	logic [gmd_pkg::SQRT_IN_W-1:0]   rad_q;
	logic [gmd_pkg::SQRT_REM_W-1:0]  rem_q, rem_sh, trial;
	logic [gmd_pkg::SQRT_ROOT_W-1:0] root_q;
	logic [3:0]                      iter_q;
	logic                            sat_q;

	assign rem_sh = {rem_q[gmd_pkg::SQRT_REM_W-3:0],
		rad_q[gmd_pkg::SQRT_IN_W-1 -: 2]};
	assign trial  = gmd_pkg::SQRT_REM_W'({root_q, 2'b01});

	logic out_free;
	assign out_free = !out_valid || out_ready;

	// Sequencer, datapath registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			win_top_q   <= '0;
			win_mid_a_q <= '0;
			win_mid_b_q <= '0;
			win_bot_q   <= '0;
			out_valid   <= 1'b0;
			emit_s1     <= 1'b0;
		end else begin
			// load a new result or drop the one just taken
			if (state_q == S_OUT && out_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						addr_s1  <= col_eff[CW-1:0];
						pixel_s1 <= pixel;
						emit_s1  <= emit_c;
						last_s1  <= last_c;
						col_q    <= col_nxt[CW-1:0];
						row_q    <= row_nxt[RW-1:0];
						state_q  <= S_RD;
					end
				end
				S_RD: begin
					// shift window, take differences around the centre
					dx_s2       <= 9'(middle_rd) - 9'(win_mid_a_q);
					dy_s2       <= 9'(win_bot_q) - 9'(win_top_q);
					last_s2     <= last_s1;
					win_top_q   <= older_rd;
					win_mid_a_q <= win_mid_b_q;
					win_mid_b_q <= middle_rd;
					win_bot_q   <= pixel_s1;
					state_q     <= emit_s1 ? S_MUL1 : S_IDLE;
				end
				S_MUL1: begin
					grad_sq_s3  <= 17'(17'($signed(dx_s2) * $signed(dx_s2))
						+ 17'($signed(dy_s2) * $signed(dy_s2)));
					scale_sq_s3 <= 16'(mag_scale_q) * 16'(mag_scale_q);
					dir_s3      <= dir_c;
					last_s3     <= last_s2;
					state_q     <= S_MUL2;
				end
				S_MUL2: begin
					rad_q   <= product[gmd_pkg::SQRT_IN_W-1:0];
					sat_q   <= |product[32:gmd_pkg::SQRT_IN_W];
					rem_q   <= '0;
					root_q  <= '0;
					iter_q  <= 4'(gmd_pkg::SQRT_ROOT_W - 1);
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					// one root bit per cycle
					rad_q <= rad_q << 2;
					if (rem_sh >= trial) begin
						rem_q  <= rem_sh - trial;
						root_q <= {root_q[gmd_pkg::SQRT_ROOT_W-2:0], 1'b1};
					end else begin
						rem_q  <= rem_sh;
						root_q <= {root_q[gmd_pkg::SQRT_ROOT_W-2:0], 1'b0};
					end
					iter_q <= iter_q - 4'd1;
					if (iter_q == 4'd0) state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						magnitude     <= sat_q ? 8'hFF : root_q[gmd_pkg::SQRT_ROOT_W-1 -: 8];
						direction     <= dir_s3;
						last_of_frame <= last_s3;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/gmd_checker.sv
// Port-level assertions for the gradient magnitude and direction core.
module gmd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] magnitude,
	input logic [1:0] direction,
	input logic       last_of_frame
);

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(magnitude)
		&& $stable(direction) && $stable(last_of_frame))
		else $error("result changed while stalled");

	// One pixel at a time: ready drops after each transaction
	a_in_single: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("pixel accepted back to back");

	// A result never appears in the cycle right after a pixel transaction
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result too early after pixel");

endmodule

bind gradient_magnitude_direction_core gmd_checker u_gmd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.magnitude     (magnitude),
	.direction     (direction),
	.last_of_frame (last_of_frame)
);
